// File: rtl/core/gsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the shortest-path engine
// Command codes, store geometry and the request and result transaction types.
// ----------------------------------------------------------------------------
package gsp_pkg;

	localparam int VERTICES = 64;
	localparam int VTX_W    = 6;
	localparam int EDGES    = VERTICES * VERTICES;
	localparam int EDGE_W   = 12;
	localparam int WGT_W    = 16;
	localparam int COST_W   = 22;
	localparam int STAMP_W  = 12;
	localparam int MAX_OUT  = 64;
	localparam int CNT_W    = 7;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD_V = 2'd1;
	localparam logic [1:0] CMD_ADD_E = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	typedef struct packed {
		logic [1:0]       command;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
		logic [WGT_W-1:0] weight;
	} gsp_req_t;

	typedef struct packed {
		logic [VTX_W-1:0]  path_vertex;
		logic [COST_W-1:0] path_cost;
		logic              found;
		logic              last;
	} gsp_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/gsp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/graph_shortest_path_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// graph_shortest_path_engine: Dijkstra shortest path over a stored graph
// Holds vertices and weighted directed edges; a query emits the path vertex
// by vertex, source first, with the Q14.8 cost on the final transaction.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   gsp_req_t command, vertices, weight
//   rsp      out  rsp_valid/rsp_ready   gsp_rsp_t vertex, cost, found, last
//
// Add vertex and add edge complete at the handshake; clear sweeps the whole
// edge RAM, as does reset before the first request is taken.
// For each selected vertex a query makes a queue scan and, but for the target,
// a relaxation pass, each stepping through every vertex on the single read
// port of the distance and edge RAMs; the parent walk and output then go
// path vertex by path vertex.
// req_ready is low while a command is in work; a stalled rsp holds the engine.
// ----------------------------------------------------------------------------
module graph_shortest_path_engine
	import gsp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output      logic     req_ready,
	input  wire gsp_req_t req,
	output      logic     rsp_valid,
	input  wire logic     rsp_ready,
	output      gsp_rsp_t rsp
);

	localparam logic [3:0] ST_CLR       = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_FAIL      = 4'd2;
	localparam logic [3:0] ST_QINIT     = 4'd3;
	localparam logic [3:0] ST_SCAN      = 4'd4;
	localparam logic [3:0] ST_SCAN_END  = 4'd5;
	localparam logic [3:0] ST_SCAN_DEC  = 4'd6;
	localparam logic [3:0] ST_RELAX     = 4'd7;
	localparam logic [3:0] ST_RELAX_END = 4'd8;
	localparam logic [3:0] ST_WALK      = 4'd9;
	localparam logic [3:0] ST_WALK_W    = 4'd10;
	localparam logic [3:0] ST_EMIT_RD   = 4'd11;
	localparam logic [3:0] ST_EMIT_WR   = 4'd12;

	logic [3:0]          state_q;
	logic [EDGE_W-1:0]   clr_q;
	logic [VTX_W-1:0]    cnt_q;
	logic                v_s1;
	logic [VTX_W-1:0]    u_s1;
	logic [VERTICES-1:0] vpres_q;
	logic [VERTICES-1:0] visited_q;
	logic [VERTICES-1:0] queued_q;
	logic [VTX_W-1:0]    src_q;
	logic [VTX_W-1:0]    tgt_q;
	logic [VTX_W-1:0]    m_q;
	logic [COST_W-1:0]   bd_q;
	logic [STAMP_W-1:0]  bst_q;
	logic                any_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [VTX_W-1:0]    walk_q;
	logic [CNT_W-1:0]    n_q;
	logic [VTX_W-1:0]    j_q;
	logic                rsp_valid_q;
	gsp_rsp_t            rsp_q;

	logic                edge_we;
	logic [EDGE_W-1:0]   edge_waddr;
	logic [WGT_W:0]      edge_wdata;
	logic [WGT_W:0]      edge_rdata;
	logic                dist_we;
	logic [VTX_W-1:0]    dist_waddr;
	logic [COST_W-1:0]   dist_wdata;
	logic [COST_W-1:0]   dist_rdata;
	logic [STAMP_W-1:0]  stamp_wdata;
	logic [STAMP_W-1:0]  stamp_rdata;
	logic                par_we;
	logic [VTX_W-1:0]    par_rdata;
	logic                path_we;
	logic [VTX_W-1:0]    path_waddr;
	logic [VTX_W-1:0]    path_wdata;
	logic [VTX_W-1:0]    path_rdata;
	logic                stamp_we;

	logic                req_hs;
	logic                slot_free;
	logic                rsp_load;
	logic                has_a;
	logic                has_b;
	logic                scan_cmp;
	logic                relax_cmp;
	logic                relax_hit;
	logic                relax_upd;
	logic                relax_enq;
	logic [COST_W-1:0]   nd;

	assign req_ready = (state_q == ST_IDLE);
	assign req_hs    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_load  = slot_free && ((state_q == ST_FAIL) || (state_q == ST_EMIT_WR));
	assign has_a     = vpres_q[req.vertex_a];
	assign has_b     = vpres_q[req.vertex_b];
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// compare stage of the queue scan
	assign scan_cmp = v_s1 && ((state_q == ST_SCAN) || (state_q == ST_SCAN_END));
	// compare stage of the neighbor pass
	assign relax_cmp = v_s1 && ((state_q == ST_RELAX) || (state_q == ST_RELAX_END));
	assign nd        = bd_q + COST_W'(edge_rdata[WGT_W-1:0]);
	assign relax_hit = relax_cmp && vpres_q[u_s1] && edge_rdata[WGT_W];
	assign relax_upd = relax_hit &&
		(!(queued_q[u_s1] || visited_q[u_s1]) || (nd < dist_rdata));
	assign relax_enq = relax_hit && !visited_q[u_s1];

	always_comb begin
		edge_we    = 1'b0;
		edge_waddr = clr_q;
		edge_wdata = '0;
		if (state_q == ST_CLR) begin
			edge_we = 1'b1;
		end else if (req_hs && (req.command == CMD_ADD_E) && has_a && has_b) begin
			edge_we    = 1'b1;
			edge_waddr = {req.vertex_a, req.vertex_b};
			edge_wdata = {1'b1, req.weight};
		end
	end

	always_comb begin
		dist_we     = relax_upd;
		dist_waddr  = u_s1;
		dist_wdata  = nd;
		stamp_we    = relax_enq;
		stamp_wdata = stamp_q;
		if (state_q == ST_QINIT) begin
			dist_we     = 1'b1;
			dist_waddr  = src_q;
			dist_wdata  = '0;
			stamp_we    = 1'b1;
			stamp_wdata = '0;
		end
	end

	assign par_we = relax_upd;

	always_comb begin
		path_we    = 1'b0;
		path_waddr = n_q[VTX_W-1:0];
		path_wdata = par_rdata;
		if ((state_q == ST_SCAN_DEC) && any_q && (m_q == tgt_q)) begin
			path_we    = 1'b1;
			path_waddr = '0;
			path_wdata = tgt_q;
		end else if (state_q == ST_WALK_W) begin
			path_we = 1'b1;
		end
	end

	gsp_ram #(.WIDTH(WGT_W + 1), .DEPTH(EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr({m_q, cnt_q}), .rdata(edge_rdata)
	);

	gsp_ram #(.WIDTH(COST_W), .DEPTH(VERTICES)) u_dist_ram (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(cnt_q), .rdata(dist_rdata)
	);

	gsp_ram #(.WIDTH(STAMP_W), .DEPTH(VERTICES)) u_stamp_ram (
		.clk(clk), .we(stamp_we), .waddr(dist_waddr), .wdata(stamp_wdata),
		.raddr(cnt_q), .rdata(stamp_rdata)
	);

	gsp_ram #(.WIDTH(VTX_W), .DEPTH(VERTICES)) u_parent_ram (
		.clk(clk), .we(par_we), .waddr(u_s1), .wdata(m_q),
		.raddr(walk_q), .rdata(par_rdata)
	);

	gsp_ram #(.WIDTH(VTX_W), .DEPTH(MAX_OUT)) u_path_ram (
		.clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
		.raddr(j_q), .rdata(path_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			vpres_q     <= '0;
			visited_q   <= '0;
			queued_q    <= '0;
			any_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			v_s1 <= 1'b0;
			u_s1 <= cnt_q;

			if (scan_cmp && queued_q[u_s1] && (!any_q || (dist_rdata < bd_q) ||
				((dist_rdata == bd_q) && (stamp_rdata > bst_q)))) begin
				any_q <= 1'b1;
				m_q   <= u_s1;
				bd_q  <= dist_rdata;
				bst_q <= stamp_rdata;
			end
			if (relax_enq) begin
				queued_q[u_s1] <= 1'b1;
				stamp_q        <= stamp_q + 1'b1;
			end

			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == EDGE_W'(EDGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_hs) begin
						src_q <= req.vertex_a;
						tgt_q <= req.vertex_b;
						unique case (req.command)
							CMD_CLEAR: begin
								vpres_q <= '0;
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							CMD_ADD_V: vpres_q[req.vertex_a] <= 1'b1;
							CMD_ADD_E: ;
							CMD_QUERY: state_q <= (has_a && has_b) ? ST_QINIT : ST_FAIL;
							default: ;
						endcase
					end
				end
				ST_FAIL: begin
					if (slot_free) begin
						rsp_q       <= '{path_vertex: '0, path_cost: '0,
							found: 1'b0, last: 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				ST_QINIT: begin
					visited_q        <= '0;
					queued_q         <= {{(VERTICES-1){1'b0}}, 1'b1} << src_q;
					stamp_q          <= STAMP_W'(1);
					any_q            <= 1'b0;
					cnt_q            <= '0;
					state_q          <= ST_SCAN;
				end
				ST_SCAN, ST_RELAX: begin
					v_s1  <= 1'b1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == VTX_W'(VERTICES - 1)) begin
						state_q <= (state_q == ST_SCAN) ? ST_SCAN_END : ST_RELAX_END;
					end
				end
				ST_SCAN_END: state_q <= ST_SCAN_DEC;
				ST_SCAN_DEC: begin
					if (!any_q) begin
						state_q <= ST_FAIL;
					end else if (m_q == tgt_q) begin
						walk_q  <= tgt_q;
						n_q     <= CNT_W'(1);
						state_q <= ST_WALK;
					end else begin
						visited_q[m_q] <= 1'b1;
						queued_q[m_q]  <= 1'b0;
						cnt_q          <= '0;
						state_q        <= ST_RELAX;
					end
				end
				ST_RELAX_END: begin
					any_q   <= 1'b0;
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_WALK: begin
					if ((walk_q != src_q) && (n_q < CNT_W'(MAX_OUT))) begin
						state_q <= ST_WALK_W;
					end else begin
						j_q     <= VTX_W'(n_q - 1'b1);
						state_q <= ST_EMIT_RD;
					end
				end
				ST_WALK_W: begin
					walk_q  <= par_rdata;
					n_q     <= n_q + 1'b1;
					state_q <= ST_WALK;
				end
				ST_EMIT_RD: state_q <= ST_EMIT_WR;
				ST_EMIT_WR: begin
					if (slot_free) begin
						rsp_q       <= '{path_vertex: path_rdata,
							path_cost: (j_q == '0) ? bd_q : '0,
							found: 1'b1, last: (j_q == '0)};
						if (j_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q - 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> rsp.last)
		else $error("failed query result without last");
	a_cost_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.path_cost == '0))
		else $error("cost on a non-final path result");
	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req.command == CMD_CLEAR)) |=> !req_ready)
		else $error("clear did not start the edge sweep");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req.command == CMD_QUERY)) |=> !req_ready)
		else $error("query accepted without going busy");
`endif

endmodule
`default_nettype wire
